// ===== rtl/rwl_pkg.sv =====
// rwl_pkg: types and constants shared by the readers/writer lock arbiter
// no dependencies; imported by every rtl module of the block but rwl_ram

package rwl_pkg;

	localparam int ID_W      = 4;   // requester id width
	localparam int ACTIVE_W  = 8;   // active_readers field width
	localparam int GRANT_CAP = 16;  // grants per step at most
	localparam int GNT_W     = $clog2(GRANT_CAP + 1);
	localparam int GIDX_W    = $clog2(GRANT_CAP);
	localparam int CMD_DEPTH = 2;   // command queue between front and back
	localparam int CMD_AW    = $clog2(CMD_DEPTH);

	typedef enum logic [1:0] {
		OPC_START_READ  = 2'd0,
		OPC_END_READ    = 2'd1,
		OPC_START_WRITE = 2'd2,
		OPC_END_WRITE   = 2'd3
	} rwl_opcode_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_NOHOLD = 2'd2
	} rwl_status_t;

	typedef enum logic {
		RWL_OP,
		RWL_SERVE
	} rwl_state_t;

	typedef struct packed {
		logic [1:0]      opcode;
		logic [ID_W-1:0] requester_id;
	} rwl_req_t;

	typedef struct packed {
		logic                grant_valid;
		logic [ID_W-1:0]     grant_id;
		logic                grant_is_writer;
		logic [1:0]          status;
		logic [ACTIVE_W-1:0] active_readers;
		logic                last;
	} rwl_res_t;

	// classified command, front to back
	typedef struct packed {
		logic            start;
		logic            reader;
		logic [ID_W-1:0] id;
	} rwl_cmd_t;

	// waiter queue entry
	typedef struct packed {
		logic            reader;
		logic [ID_W-1:0] id;
	} rwl_entry_t;

	// grant write into the result buffer
	typedef struct packed {
		logic              en;
		logic [GIDX_W-1:0] idx;
		logic [ID_W-1:0]   id;
		logic              writer;
	} rwl_gwr_t;

	// end of step summary
	typedef struct packed {
		logic                en;
		rwl_status_t         status;
		logic [ACTIVE_W-1:0] readers;
		logic [GNT_W-1:0]    n;
	} rwl_done_t;

endpackage

// ===== rtl/fifo_fair_reader_writer_lock.sv =====
// fifo_fair_reader_writer_lock: fifo-fair readers/writer lock arbiter, top level
// depends on rwl_pkg, rwl_front, rwl_back, rwl_out (and rwl_ram below rwl_back)
// step: the op state applies the request, then the serve state grants waiters from the
// head until a writer, the grant cap, an empty queue or a waiter it cannot grant ends it
// requests can queue in the front while results wait; a step's serve phase waits until
// the previous step's results are all popped
// reset: arst_n clears pointers, counts, lock state and flags; queue contents are not cleared

module fifo_fair_reader_writer_lock import rwl_pkg::*; #(
	parameter int QUEUE_DEPTH = 16,
	parameter int MAX_READERS = 255
) (
	input  logic     clk,
	input  logic     arst_n,
	// request side
	input  logic     push,
	output logic     full,
	input  rwl_req_t req,
	// result side
	output logic     empty,
	input  logic     pop,
	output rwl_res_t res
);

	// front to back command handoff
	logic      cmd_valid;
	logic      cmd_pop;
	rwl_cmd_t  cmd;
	// back to result buffer
	rwl_gwr_t  gwr;
	rwl_done_t done;
	logic      out_busy;

	// front: take the request transfer, decode opcode, buffer it
	rwl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	// back: apply the request to the lock state, then, once the result buffer is free,
	// walk the waiter queue head one entry per cycle, writing each grant into the buffer
	rwl_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.MAX_READERS (MAX_READERS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.out_busy  (out_busy),
		.gwr       (gwr),
		.done      (done)
	);

	// result buffer: holds one step's grants so that every result carries
	// the reader count as it stands after the whole step
	rwl_out u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.gwr    (gwr),
		.done   (done),
		.busy   (out_busy),
		.empty  (empty),
		.pop    (pop),
		.res    (res)
	);

endmodule

// ===== rtl/rwl_ram.sv =====
// rwl_ram: generic single write port, single read port ram with registered read
// no dependencies

module rwl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/rwl_front.sv =====
// rwl_front: accepts lock requests, classifies them, small command queue
// depends on rwl_pkg

module rwl_front import rwl_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  rwl_req_t req,
	output logic     cmd_valid,
	output rwl_cmd_t cmd,
	input  logic     cmd_pop
);

	rwl_cmd_t              slot_q [CMD_DEPTH];
	logic [CMD_AW-1:0]     wp_q, rp_q;
	logic [CMD_AW:0]       cnt_q;
	rwl_cmd_t              cls;
	logic                  take;
	logic                  give;

	// opcode classification
	always_comb begin
		cls.id = req.requester_id;
		case (rwl_opcode_t'(req.opcode))
			OPC_START_READ:  begin cls.start = 1'b1; cls.reader = 1'b1; end
			OPC_END_READ:    begin cls.start = 1'b0; cls.reader = 1'b1; end
			OPC_START_WRITE: begin cls.start = 1'b1; cls.reader = 1'b0; end
			OPC_END_WRITE:   begin cls.start = 1'b0; cls.reader = 1'b0; end
			default:         begin cls.start = 1'b0; cls.reader = 1'b0; end
		endcase
	end

	assign full      = (cnt_q == (CMD_AW+1)'(CMD_DEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = slot_q[rp_q];
	assign take      = push && !full;
	assign give      = cmd_pop && cmd_valid;

	always_ff @(posedge clk) begin
		if (take) begin
			slot_q[wp_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (take) begin
				wp_q <= wp_q + 1'b1;
			end
			if (give) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (CMD_AW+1)'(take) - (CMD_AW+1)'(give);
		end
	end

endmodule

// ===== rtl/rwl_back.sv =====
// rwl_back: lock state, waiter queue and head serving sequencer
// depends on rwl_pkg and rwl_ram

module rwl_back import rwl_pkg::*; #(
	parameter int QUEUE_DEPTH = 16,
	parameter int MAX_READERS = 255
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	input  rwl_cmd_t  cmd,
	output logic      cmd_pop,
	input  logic      out_busy,
	output rwl_gwr_t  gwr,
	output rwl_done_t done
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int RW = $clog2(MAX_READERS + 1);
	localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(QUEUE_DEPTH);
	localparam logic [RW-1:0] RC_MAX    = RW'(MAX_READERS);
	localparam logic [GNT_W-1:0] N_LAST = GNT_W'(GRANT_CAP - 1);

	rwl_state_t       state_q, state_d;
	logic [AW-1:0]    head_q, head_d, tail_q, tail_d, head_inc;
	logic [CW-1:0]    count_q, count_d;
	logic [RW-1:0]    rc_q, rc_d;
	logic             wact_q, wact_d;
	rwl_status_t      status_q, status_d;
	logic [GNT_W-1:0] n_q, n_d;
	rwl_entry_t       byp_q;
	logic             byp_en_q;

	logic             we, re;
	logic [AW-1:0]    raddr;
	rwl_entry_t       wdata, rdata, entry;
	logic             op_act, serve_act, can_grant, grant, finish;

	rwl_ram #(
		.WIDTH ($bits(rwl_entry_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_wq (
		.clk   (clk),
		.we    (we),
		.waddr (tail_q),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign entry    = byp_en_q ? byp_q : rdata;
	assign head_inc = (head_q == LAST_SLOT) ? '0 : head_q + 1'b1;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			RWL_OP:    if (cmd_valid) state_d = RWL_SERVE;
			RWL_SERVE: if (finish) state_d = RWL_OP;
			default:   state_d = RWL_OP;
		endcase
	end

	// datapath and outputs
	always_comb begin
		op_act    = (state_q == RWL_OP) && cmd_valid;
		serve_act = (state_q == RWL_SERVE) && !out_busy;
		can_grant = (count_q != '0) && !wact_q &&
		            (entry.reader ? (rc_q != RC_MAX) : (rc_q == '0));
		grant     = serve_act && can_grant;
		finish    = serve_act && (!can_grant || !entry.reader ||
		            count_q == CW'(1) || n_q == N_LAST);

		head_d   = head_q;
		tail_d   = tail_q;
		count_d  = count_q;
		rc_d     = rc_q;
		wact_d   = wact_q;
		status_d = status_q;
		n_d      = n_q;
		we       = 1'b0;
		wdata    = '{reader: cmd.reader, id: cmd.id};
		re       = 1'b0;
		raddr    = head_q;
		cmd_pop  = op_act;

		if (op_act) begin
			status_d = ST_OK;
			n_d      = '0;
			re       = 1'b1;
			if (cmd.start) begin
				if (count_q == FULL_CNT) begin
					status_d = ST_FULL;
				end else begin
					we      = 1'b1;
					tail_d  = (tail_q == LAST_SLOT) ? '0 : tail_q + 1'b1;
					count_d = count_q + 1'b1;
				end
			end else if (cmd.reader) begin
				if (rc_q == '0) status_d = ST_NOHOLD;
				else rc_d = rc_q - 1'b1;
			end else begin
				if (!wact_q) status_d = ST_NOHOLD;
				else wact_d = 1'b0;
			end
		end

		if (grant) begin
			head_d  = head_inc;
			count_d = count_q - 1'b1;
			n_d     = n_q + 1'b1;
			if (entry.reader) rc_d = rc_q + 1'b1;
			else wact_d = 1'b1;
			if (!finish) begin
				re    = 1'b1;
				raddr = head_inc;
			end
		end

		gwr.en      = grant;
		gwr.idx     = n_q[GIDX_W-1:0];
		gwr.id      = entry.id;
		gwr.writer  = !entry.reader;
		done.en      = finish;
		done.status  = status_q;
		done.readers = ACTIVE_W'(rc_d);
		done.n       = n_d;
	end

	// forward a head entry written in the same cycle it is read
	always_ff @(posedge clk) begin
		if (re) begin
			byp_q <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= RWL_OP;
			head_q   <= '0;
			tail_q   <= '0;
			count_q  <= '0;
			rc_q     <= '0;
			wact_q   <= 1'b0;
			status_q <= ST_OK;
			n_q      <= '0;
			byp_en_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			head_q   <= head_d;
			tail_q   <= tail_d;
			count_q  <= count_d;
			rc_q     <= rc_d;
			wact_q   <= wact_d;
			status_q <= status_d;
			n_q      <= n_d;
			if (re) begin
				byp_en_q <= we && (tail_q == raddr);
			end
		end
	end

endmodule

// ===== rtl/rwl_out.sv =====
// rwl_out: result buffer for one step, drained one result per transfer
// depends on rwl_pkg

module rwl_out import rwl_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  rwl_gwr_t  gwr,
	input  rwl_done_t done,
	output logic      busy,
	output logic      empty,
	input  logic      pop,
	output rwl_res_t  res
);

	rwl_entry_t          ent_q [GRANT_CAP];
	logic [GNT_W-1:0]    n_q;
	logic [GIDX_W-1:0]   idx_q;
	rwl_status_t         status_q;
	logic [ACTIVE_W-1:0] readers_q;
	logic                busy_q;
	logic                has_grant, is_last;
	rwl_entry_t          cur;

	assign cur       = ent_q[idx_q];
	assign has_grant = (n_q != '0);
	assign is_last   = !has_grant || ({1'b0, idx_q} == n_q - 1'b1);
	assign busy      = busy_q;
	assign empty     = !busy_q;

	always_comb begin
		res.grant_valid     = has_grant;
		res.grant_id        = has_grant ? cur.id : '0;
		res.grant_is_writer = has_grant && !cur.reader;
		res.status          = status_q;
		res.active_readers  = readers_q;
		res.last            = is_last;
	end

	always_ff @(posedge clk) begin
		if (gwr.en) begin
			ent_q[gwr.idx] <= '{reader: !gwr.writer, id: gwr.id};
		end
		if (done.en) begin
			n_q       <= done.n;
			status_q  <= done.status;
			readers_q <= done.readers;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else begin
			if (done.en) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (pop && busy_q) begin
				if (is_last) busy_q <= 1'b0;
				else idx_q <= idx_q + 1'b1;
			end
		end
	end

endmodule

// ===== rtl/rwl_checker.sv =====
// rwl_checker: port level assertions for the lock arbiter, bound to the top level
// depends on rwl_pkg and fifo_fair_reader_writer_lock

module rwl_checker import rwl_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     empty,
	input logic     pop,
	input rwl_res_t res
);

	// a waiting result holds until its transfer
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(res))
		else $error("result changed while stalled");

	// a result without a grant is a whole step on its own
	a_empty_res: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !res.grant_valid |->
			res.last && res.grant_id == '0 && !res.grant_is_writer)
		else $error("malformed empty result");

	// a write grant ends its step
	a_writer_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && res.grant_valid && res.grant_is_writer |-> res.last)
		else $error("write grant not last");

	// results within one step share status and reader count
	a_step_fields: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && pop && !res.last |=>
			!empty && res.status == $past(res.status) &&
			res.active_readers == $past(res.active_readers))
		else $error("step fields differ across results");

	// status is always one of the defined codes
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> res.status == ST_OK || res.status == ST_FULL ||
			res.status == ST_NOHOLD)
		else $error("bad status code");

endmodule

bind fifo_fair_reader_writer_lock rwl_checker u_rwl_checker (.*);

// ===== bench/tb_top.sv =====
// tb_top: self-checking bench for the fifo-fair readers/writer lock arbiter
// depends on rwl_pkg and fifo_fair_reader_writer_lock; a scoreboard class predicts grants
`timescale 1ns / 100ps

module tb_top;
	import rwl_pkg::*;

	localparam int WAIT_DEPTH  = 16;      // waiter queue depth of the block
	localparam int READER_MAX  = 255;     // concurrent readers allowed
	localparam int CYCLE_LIMIT = 200000;  // watchdog, far above the slowest correct run
	localparam int DRAIN_GAP   = 30;      // quiet cycles after the last expected transfer

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     push = 1'b0;
	logic     full;
	rwl_req_t req = '0;
	logic     empty;
	logic     pop = 1'b0;
	rwl_res_t res;

	int cycles = 0;
	bit quiet = 1'b0;  // no idling on either side in the closing stretch

	// lock predictor plus the queue of grants still owed by the block
	class lock_scoreboard;
		logic            waiter_reader [WAIT_DEPTH];
		logic [ID_W-1:0] waiter_id [WAIT_DEPTH];
		int              head;
		int              tail;
		int              count;
		int              readers;
		bit              writer;
		rwl_res_t        due [$];
		int              errors;
		int              checked;

		function new();
			head = 0;
			tail = 0;
			count = 0;
			readers = 0;
			writer = 0;
			errors = 0;
			checked = 0;
		endfunction

		task report(input string what);
			errors++;
			$display("mismatch at cycle %0d: %s", cycles, what);
		endtask

		// one accepted request: update the lock and queue the grants it causes
		function void note_request(input rwl_req_t r);
			rwl_status_t st;
			rwl_res_t    one;
			rwl_res_t    batch [$];
			logic        head_reader;
			st = ST_OK;
			case (r.opcode)
				OPC_START_READ, OPC_START_WRITE: begin
					if (count >= WAIT_DEPTH) begin
						st = ST_FULL;
					end else begin
						waiter_reader[tail] = (r.opcode == OPC_START_READ);
						waiter_id[tail] = r.requester_id;
						tail = (tail + 1) % WAIT_DEPTH;
						count++;
					end
				end
				OPC_END_READ: begin
					if (readers == 0)
						st = ST_NOHOLD;
					else
						readers--;
				end
				default: begin
					if (!writer)
						st = ST_NOHOLD;
					else
						writer = 0;
				end
			endcase
			// serve the head: one writer or a run of readers, capped per step
			while (count > 0 && batch.size() < GRANT_CAP) begin
				head_reader = waiter_reader[head];
				if (head_reader) begin
					if (writer || readers >= READER_MAX)
						break;
					readers++;
				end else begin
					if (writer || readers != 0)
						break;
					writer = 1;
				end
				one = '0;
				one.grant_valid = 1'b1;
				one.grant_id = waiter_id[head];
				one.grant_is_writer = !head_reader;
				batch.push_back(one);
				head = (head + 1) % WAIT_DEPTH;
				count--;
				if (!head_reader)
					break;
			end
			if (batch.size() == 0)
				batch.push_back('0);
			foreach (batch[i]) begin
				one = batch[i];
				one.status = st;
				one.active_readers = 8'(readers);
				one.last = (i == batch.size() - 1);
				due.push_back(one);
			end
		endfunction

		task check_result(input rwl_res_t got);
			rwl_res_t want;
			checked++;
			if (due.size() == 0) begin
				report($sformatf("result %0d with nothing outstanding", checked));
				return;
			end
			want = due.pop_front();
			if (got.grant_valid !== want.grant_valid)
				report($sformatf("result %0d grant_valid got %0d want %0d",
					checked, got.grant_valid, want.grant_valid));
			if (got.grant_id !== want.grant_id)
				report($sformatf("result %0d grant_id got %0d want %0d",
					checked, got.grant_id, want.grant_id));
			if (got.grant_is_writer !== want.grant_is_writer)
				report($sformatf("result %0d grant_is_writer got %0d want %0d",
					checked, got.grant_is_writer, want.grant_is_writer));
			if (got.status !== want.status)
				report($sformatf("result %0d status got %0d want %0d",
					checked, got.status, want.status));
			if (got.active_readers !== want.active_readers)
				report($sformatf("result %0d active_readers got %0d want %0d",
					checked, got.active_readers, want.active_readers));
			if (got.last !== want.last)
				report($sformatf("result %0d last got %0d want %0d",
					checked, got.last, want.last));
		endtask
	endclass

	lock_scoreboard sb = new();

	fifo_fair_reader_writer_lock dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.req    (req),
		.empty  (empty),
		.pop    (pop),
		.res    (res)
	);

	always #5 clk = ~clk;

	// watchdog
	initial begin
		while (cycles < CYCLE_LIMIT)
			@(posedge clk) cycles++;
		$display("status: fail");
		$finish;
	end

	// offer one request until the block takes it, then maybe leave a gap
	task automatic send_item(input rwl_opcode_t op, input logic [ID_W-1:0] id);
		rwl_req_t r;
		r.opcode = op;
		r.requester_id = id;
		push <= 1'b1;
		req <= r;
		do @(posedge clk); while (full);
		// transfer happened at this edge
		sb.note_request(r);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// mostly well-formed traffic: releases follow what is held, starts pile up
	function automatic rwl_opcode_t pick_op();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 10)
			return rwl_opcode_t'($urandom_range(0, 3));  // noise, stray releases too
		else if (sb.writer && roll < 40)
			return OPC_END_WRITE;
		else if (sb.readers > 0 && roll < 58)
			return OPC_END_READ;
		else if (roll < 82)
			return OPC_START_READ;
		return OPC_START_WRITE;
	endfunction

	// result side: random pop bursts, one long hold-off, calm stretches
	initial begin
		int idle_left;
		bit held;
		idle_left = 0;
		held = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (pop && !empty)
				sb.check_result(res);
			if (!held && sb.checked >= 60) begin
				// long stall so the request side backs up and full rises
				held = 1'b1;
				idle_left = 300;
				pop <= 1'b0;
			end else if (idle_left > 0) begin
				idle_left--;
				pop <= 1'b0;
			end else if (!quiet && ((cycles / 97) % 4) != 0
					&& $urandom_range(0, 4) == 0) begin
				idle_left = $urandom_range(0, 3);
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// request side
	initial begin
		int guard;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// releases with nothing held
		send_item(OPC_END_READ, 4'd0);
		send_item(OPC_END_WRITE, 4'd15);
		// writer holds, sixteen readers fill the waiter queue
		send_item(OPC_START_WRITE, 4'd15);
		for (int i = 0; i < WAIT_DEPTH; i++)
			send_item(OPC_START_READ, 4'(i));
		// queue full: both kinds of start are rejected
		send_item(OPC_START_WRITE, 4'd0);
		send_item(OPC_START_READ, 4'd9);
		// writer leaves: the whole reader run is granted, sixteen results
		send_item(OPC_END_WRITE, 4'd15);
		send_item(OPC_END_READ, 4'd3);
		// writer queues behind readers, then a release of a write nobody holds
		send_item(OPC_START_WRITE, 4'd7);
		send_item(OPC_END_WRITE, 4'd7);

		for (int i = 0; i < 10; i++)
			send_item(pick_op(), 4'($urandom_range(0, 15)));

		// drive the reader count to its ceiling with readers still waiting
		guard = 0;
		while (!(sb.readers == READER_MAX && sb.count >= 3) && guard < 800) begin
			if (sb.writer)
				send_item(OPC_END_WRITE, 4'($urandom_range(0, 15)));
			else if (sb.count > 0 && !sb.waiter_reader[sb.head])
				send_item(OPC_END_READ, 4'($urandom_range(0, 15)));
			else
				send_item(OPC_START_READ, 4'($urandom_range(0, 15)));
			guard++;
		end
		// each reader leaving lets exactly one waiting reader in
		send_item(OPC_START_WRITE, 4'($urandom_range(0, 15)));
		send_item(OPC_END_READ, 4'($urandom_range(0, 15)));
		send_item(OPC_END_READ, 4'($urandom_range(0, 15)));

		for (int i = 0; i < 30; i++) begin
			quiet = (i >= 20);
			send_item(pick_op(), 4'($urandom_range(0, 15)));
		end
		push <= 1'b0;

		while (sb.due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_GAP) @(posedge clk);

		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/rwl_pkg.sv
rtl/rwl_ram.sv
rtl/rwl_front.sv
rtl/rwl_back.sv
rtl/rwl_out.sv
rtl/fifo_fair_reader_writer_lock.sv
rtl/rwl_checker.sv
bench/tb_top.sv
